// ===== rtl/core/rhcb_pkg.sv =====
package rhcb_pkg;

   // Field widths of the request and response items.
   localparam int BYTE_W   = 8;
   localparam int FP_W     = 23;
   localparam int LEN_W    = 17;
   localparam int REASON_W = 2;
   localparam int NUMBER_W = 32;

   // Window and chunk limits.
   localparam int MAX_WINDOW = 64;
   localparam int WIN_IDX_W  = $clog2(MAX_WINDOW);
   localparam int WSIZE_W    = 7;
   localparam int MAX_CHUNK  = 65536;
   localparam int MASKB_W    = 5;
   localparam int MIN_W      = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_BITS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CHUNK_SIZE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHUNK_SIZE = 3'd3;

   // Register values after reset.
   localparam logic [WSIZE_W-1:0] RESET_WINDOW_SIZE = 7'd48;
   localparam logic [MASKB_W-1:0] RESET_MASK_BITS   = 5'd13;
   localparam logic [MIN_W-1:0]   RESET_MIN_CHUNK   = 16'd2048;
   localparam logic [LEN_W-1:0]   RESET_MAX_CHUNK   = 17'd16384;

   localparam int FP_BASE = 257;

   typedef enum logic [REASON_W-1:0] {
      CUT_ANCHOR  = 2'd0,
      CUT_MAXIMUM = 2'd1,
      CUT_EOS     = 2'd2
   } cut_reason_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0]    chunk_length;
      logic [REASON_W-1:0] cut_reason;
      logic [NUMBER_W-1:0] chunk_number;
      logic [FP_W-1:0]     window_fingerprint;
   } rsp_payload_type;

   // Control from the fingerprint logic to the window chain.
   typedef struct packed {
      logic                 shift;
      logic [WIN_IDX_W-1:0] tap_sel;
   } win_ctrl_type;

   typedef logic [MAX_WINDOW:0][FP_W-1:0] pow_table_type;

   // Powers of the base modulo 2^23, built at elaboration.
   function automatic pow_table_type build_pow_table();
      pow_table_type tbl;
      logic [FP_W+9-1:0] prod;
      tbl[0] = FP_W'(1);
      for (int k = 1; k <= MAX_WINDOW; k++) begin
         prod   = (FP_W+9)'(tbl[k-1]) * (FP_W+9)'(FP_BASE);
         tbl[k] = prod[FP_W-1:0];
      end
      return tbl;
   endfunction

   localparam pow_table_type POW_TABLE = build_pow_table();

endpackage

// ===== rtl/core/rhcb_window_cell.sv =====
module rhcb_window_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic [7:0] byte_in,
   output logic [7:0] byte_out
);
   logic [7:0] data_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= byte_in;
      end
   end

   assign byte_out = data_ff;
endmodule

// ===== rtl/core/rhcb_window_chain.sv =====
module rhcb_window_chain (
   input  logic                  clock,
   input  rhcb_pkg::win_ctrl_type ctrl,
   input  logic [7:0]            byte_in,
   output logic [7:0]            tap_byte
);
   import rhcb_pkg::*;

   // Cell 0 holds the newest byte; cell k holds the byte taken k requests earlier.
   logic [BYTE_W-1:0] cell_q [0:MAX_WINDOW-1];

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         rhcb_window_cell u_cell (
            .clock    (clock),
            .shift    (ctrl.shift),
            .byte_in  (byte_in),
            .byte_out (cell_q[k])
         );
      end else begin : g_body
         rhcb_window_cell u_cell (
            .clock    (clock),
            .shift    (ctrl.shift),
            .byte_in  (cell_q[k-1]),
            .byte_out (cell_q[k])
         );
      end
   end

   assign tap_byte = cell_q[ctrl.tap_sel];
endmodule

// ===== rtl/core/rolling_hash_chunk_boundary_top.sv =====
// Content-defined chunker with a Rabin-Karp rolling fingerprint (base 257,
// modulo 2^23) over a window of 2 to 64 bytes.
// The request channel (req_valid, req_ready, req_payload) carries one stream
// byte and an end-of-stream flag per request. The response channel (rsp_valid,
// rsp_ready, rsp_payload) carries one item per chunk cut: its length, the
// cut reason, the running chunk number and the fingerprint at the cut.
// The configuration channel (csr_valid, csr_ready, csr_index, csr_data) is
// always ready and should only be written while no response is pending.
// Each request is processed in the cycle it is accepted; a response, when the
// request causes one, is valid in the next cycle. One request is accepted
// every cycle while the response channel is not stalled; the per-byte
// fingerprint update (one 8 by 23 bit product and a few adds) is combinational.
// The window bytes sit in a chain of byte cells that shifts on every request;
// the byte leaving the window is picked from the chain by the window size.
// When the receiver stalls, the response stays in its output register and a
// new request is still taken if the response is consumed in the same cycle;
// otherwise req_ready drops. Synchronous reset clears the fingerprint, the
// byte and chunk counters and the response, and loads the default register
// values; the window cells are not cleared and need no clearing pass.
module rolling_hash_chunk_boundary_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rhcb_pkg::req_payload_type               req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rhcb_pkg::rsp_payload_type               rsp_payload,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rhcb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [rhcb_pkg::CSR_DATA_W-1:0]         csr_data
);
   import rhcb_pkg::*;

   // Configuration, kept in the form the datapath uses: clamped window size,
   // the base raised to the window size, an expanded mask and a clamped maximum.
   logic [WSIZE_W-1:0] wsize_ff, wsize_in;
   logic [FP_W-1:0]    roll_coef_ff, roll_coef_in;
   logic [FP_W-1:0]    mask_ff, mask_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [LEN_W-1:0]   maxc_ff, maxc_in;

   // Chunk state.
   logic [FP_W-1:0]     fp_ff, fp_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic [NUMBER_W-1:0] number_ff, number_in;

   // Response register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              csr_write;
   win_ctrl_type      win_ctrl;
   logic [BYTE_W-1:0] old_byte;
   logic [BYTE_W-1:0] new_byte;
   logic              filling;
   logic [WSIZE_W-1:0] fill_idx;
   logic [BYTE_W-1:0] mul_a;
   logic [FP_W-1:0]   mul_b;
   logic [FP_W-1:0]   product;
   logic [FP_W-1:0]   fp_next;
   logic [LEN_W-1:0]  cnt_next;
   logic              cut;
   cut_reason_type    reason;
   logic [WSIZE_W-1:0] w_clamped;
   logic [LEN_W-1:0]   max_clamped;
   logic [FP_W-1:0]    mask_new;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign new_byte  = req_payload.data_byte;

   // The byte leaving the window was taken window-size requests ago.
   assign win_ctrl.shift   = accept;
   assign win_ctrl.tap_sel = WIN_IDX_W'(wsize_ff - WSIZE_W'(1));

   rhcb_window_chain u_chain (
      .clock    (clock),
      .ctrl     (win_ctrl),
      .byte_in  (new_byte),
      .tap_byte (old_byte)
   );

   // Register writes, clamped on the way in.
   always_comb begin
      if (csr_data[WSIZE_W-1:0] < WSIZE_W'(2)) begin
         w_clamped = WSIZE_W'(2);
      end else if (csr_data[WSIZE_W-1:0] > WSIZE_W'(MAX_WINDOW)) begin
         w_clamped = WSIZE_W'(MAX_WINDOW);
      end else begin
         w_clamped = csr_data[WSIZE_W-1:0];
      end
      if (csr_data[LEN_W-1:0] > LEN_W'(MAX_CHUNK)) begin
         max_clamped = LEN_W'(MAX_CHUNK);
      end else begin
         max_clamped = csr_data[LEN_W-1:0];
      end
      for (int i = 0; i < FP_W; i++) begin
         mask_new[i] = (MASKB_W'(i) < csr_data[MASKB_W-1:0]) || (i >= 2**MASKB_W);
      end
   end

   always_comb begin
      wsize_in     = wsize_ff;
      roll_coef_in = roll_coef_ff;
      mask_in      = mask_ff;
      min_in       = min_ff;
      maxc_in      = maxc_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_SIZE: begin
               wsize_in     = w_clamped;
               roll_coef_in = POW_TABLE[w_clamped];
            end
            CSR_MASK_BITS: begin
               mask_in = mask_new;
            end
            CSR_MIN_CHUNK_SIZE: begin
               min_in = csr_data[MIN_W-1:0];
            end
            CSR_MAX_CHUNK_SIZE: begin
               maxc_in = max_clamped;
            end
            default: begin
            end
         endcase
      end
   end

   // Fingerprint update. While the window fills, the new byte is weighted by
   // the power for its place in the window. Once it is full, the update is
   // 257 * fp + byte - old_byte * 257^w, all modulo 2^23; one multiplier
   // serves both cases.
   assign filling  = cnt_ff < LEN_W'(wsize_ff);
   assign fill_idx = wsize_ff - WSIZE_W'(1) - cnt_ff[WSIZE_W-1:0];

   always_comb begin
      if (filling) begin
         mul_a = new_byte;
         mul_b = POW_TABLE[fill_idx];
      end else begin
         mul_a = old_byte;
         mul_b = roll_coef_ff;
      end
      product = FP_W'(mul_a) * mul_b;
      if (filling) begin
         fp_next = fp_ff + product;
      end else begin
         fp_next = {fp_ff[FP_W-BYTE_W-1:0], {BYTE_W{1'b0}}} + fp_ff
                   + FP_W'(new_byte) - product;
      end
      cnt_next = cnt_ff + LEN_W'(1);
   end

   // Cut decision. Anchor and maximum cuts are only considered once the window
   // is full and the chunk has reached the minimum size; an anchor match wins
   // over the maximum. The end-of-stream flag flushes whatever remains.
   always_comb begin
      cut    = 1'b0;
      reason = CUT_EOS;
      if (!filling && (cnt_next >= LEN_W'(min_ff))) begin
         if ((fp_next & mask_ff) == '0) begin
            cut    = 1'b1;
            reason = CUT_ANCHOR;
         end else if (cnt_next >= maxc_ff) begin
            cut    = 1'b1;
            reason = CUT_MAXIMUM;
         end
      end
      if (!cut && req_payload.end_of_stream) begin
         cut    = 1'b1;
         reason = CUT_EOS;
      end
   end

   always_comb begin
      fp_in        = fp_ff;
      cnt_in       = cnt_ff;
      number_in    = number_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         if (cut) begin
            fp_in                          = '0;
            cnt_in                         = '0;
            number_in                      = number_ff + NUMBER_W'(1);
            rsp_valid_in                   = 1'b1;
            rsp_data_in.chunk_length       = cnt_next;
            rsp_data_in.cut_reason         = reason;
            rsp_data_in.chunk_number       = number_ff;
            rsp_data_in.window_fingerprint = fp_next;
         end else begin
            fp_in  = fp_next;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff     <= RESET_WINDOW_SIZE;
         roll_coef_ff <= POW_TABLE[RESET_WINDOW_SIZE];
         mask_ff      <= FP_W'((1 << RESET_MASK_BITS) - 1);
         min_ff       <= RESET_MIN_CHUNK;
         maxc_ff      <= RESET_MAX_CHUNK;
         fp_ff        <= '0;
         cnt_ff       <= '0;
         number_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         roll_coef_ff <= roll_coef_in;
         mask_ff      <= mask_in;
         min_ff       <= min_in;
         maxc_ff      <= maxc_in;
         fp_ff        <= fp_in;
         cnt_ff       <= cnt_in;
         number_ff    <= number_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // A response held by a stalled receiver must block new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while a stalled response is pending");

   // Every cut restarts the chunk with an empty count and fingerprint.
   a_cut_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && cut) |=> (cnt_ff == '0) && (fp_ff == '0))
      else $error("chunk state not cleared after a cut");

   // The open chunk never grows past the largest chunk size.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LEN_W'(MAX_CHUNK))
      else $error("chunk byte count beyond the maximum chunk size");

   // A response never reports an empty chunk.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.chunk_length != '0))
      else $error("response with zero chunk length");
`endif
endmodule
